### rtl/core/rcpc_pkg.sv
// Shared types and constants for the RC pulse capture core.
// Holds request/result payload structs, register map and reset values.
// No dependencies.
package rcpc_pkg;

    // Register map of the configuration port
    typedef enum logic [2:0] {
        REG_MOTOR_LOW     = 3'd0,
        REG_MOTOR_HIGH    = 3'd1,
        REG_SERVO_LOW     = 3'd2,
        REG_SERVO_HIGH    = 3'd3,
        REG_BUTTON_LOW    = 3'd4,
        REG_BUTTON_HIGH   = 3'd5,
        REG_MOTOR_NEUTRAL = 3'd6,
        REG_SERVO_NEUTRAL = 3'd7
    } cfg_idx_t;

    // Channel codes of a request; the fourth code is unused
    localparam logic [1:0] CH_MOTOR  = 2'd0;
    localparam logic [1:0] CH_SERVO  = 2'd1;
    localparam logic [1:0] CH_SWITCH = 2'd2;

    localparam int NUM_CH = 3;

    typedef struct packed {
        logic [11:0] motor_low;
        logic [11:0] motor_high;
        logic [11:0] servo_low;
        logic [11:0] servo_high;
        logic [11:0] button_low;
        logic [11:0] button_high;
        logic [11:0] motor_neutral;
        logic [11:0] servo_neutral;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        motor_low:     12'd1220,
        motor_high:    12'd2012,
        servo_low:     12'd928,
        servo_high:    12'd1888,
        button_low:    12'd1204,
        button_high:   12'd1710,
        motor_neutral: 12'd1528,
        servo_neutral: 12'd1376
    };

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] edge_time;
    } req_t;

    typedef struct packed {
        logic        width_accepted;
        logic [15:0] measured_width;
        logic        motor_write;
        logic [11:0] motor_command;
        logic        servo_write;
        logic [11:0] servo_command;
        logic        locked;
        logic        led_on;
    } rsp_t;

endpackage

### rtl/core/rcpc_cfg_regs.sv
// Configuration register bank of the RC pulse capture core.
// Depends on rcpc_pkg for the register map and reset values.
module rcpc_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  rcpc_pkg::cfg_idx_t cfg_index,
    input  logic [11:0]       cfg_data,
    output rcpc_pkg::cfg_t    cfg
);
    import rcpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MOTOR_LOW:     cfg_next.motor_low     = cfg_data;
                REG_MOTOR_HIGH:    cfg_next.motor_high    = cfg_data;
                REG_SERVO_LOW:     cfg_next.servo_low     = cfg_data;
                REG_SERVO_HIGH:    cfg_next.servo_high    = cfg_data;
                REG_BUTTON_LOW:    cfg_next.button_low    = cfg_data;
                REG_BUTTON_HIGH:   cfg_next.button_high   = cfg_data;
                REG_MOTOR_NEUTRAL: cfg_next.motor_neutral = cfg_data;
                REG_SERVO_NEUTRAL: cfg_next.servo_neutral = cfg_data;
            endcase
        end
    end

    // Hold the bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/rcpc_measure.sv
// Interval measurement, window test and arming lock of the RC pulse capture core.
// Keeps the per-channel last edge time and the lock flag; builds one result.
// Depends on rcpc_pkg.
module rcpc_measure #(
    parameter int ARM_TOLERANCE = 50
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rcpc_pkg::cfg_t cfg,
    input  rcpc_pkg::req_t req,
    input  logic           advance,
    output rcpc_pkg::rsp_t rsp
);
    import rcpc_pkg::*;

    localparam logic [32:0] TOL = 33'(ARM_TOLERANCE);

    logic [31:0] last_time_reg [NUM_CH];
    logic [31:0] last_time_next [NUM_CH];
    logic        lock_reg;
    logic        lock_next;

    logic        ch_valid;
    logic [31:0] last_time;
    logic [11:0] win_lo;
    logic [11:0] win_hi;
    logic [31:0] dt;
    logic [34:0] dt5;
    logic [13:0] lo4;
    logic [14:0] hi6;
    logic        in_win;
    logic [11:0] dt_sat12;
    logic [32:0] dt_ext;
    logic        near_lock;
    logic        near_unlock;

    // Select the channel's last edge and window
    always_comb
    begin
        ch_valid  = 1'b1;
        last_time = last_time_reg[0];
        win_lo    = cfg.motor_low;
        win_hi    = cfg.motor_high;
        case (req.req_type)
            CH_MOTOR:
            begin
                last_time = last_time_reg[0];
                win_lo    = cfg.motor_low;
                win_hi    = cfg.motor_high;
            end
            CH_SERVO:
            begin
                last_time = last_time_reg[1];
                win_lo    = cfg.servo_low;
                win_hi    = cfg.servo_high;
            end
            CH_SWITCH:
            begin
                last_time = last_time_reg[2];
                win_lo    = cfg.button_low;
                win_hi    = cfg.button_high;
            end
            default:
            begin
                ch_valid = 1'b0;
            end
        endcase
    end

    // Measure the interval and test it against 0.8*low .. 1.2*high as dt*5 vs low*4, high*6
    assign dt       = req.edge_time - last_time;
    assign dt5      = {3'b000, dt} + {1'b0, dt, 2'b00};
    assign lo4      = {win_lo, 2'b00};
    assign hi6      = {1'b0, win_hi, 2'b00} + {2'b00, win_hi, 1'b0};
    assign in_win   = ch_valid && (dt5 > 35'(lo4)) && (dt5 < 35'(hi6));
    assign dt_sat12 = (dt[31:12] != '0) ? 12'hFFF : dt[11:0];

    // Check the switch width against the lock and unlock positions
    assign dt_ext      = {1'b0, dt};
    assign near_lock   = (dt_ext < (33'(cfg.button_low) + TOL))
                      && ((dt_ext + TOL) > 33'(cfg.button_low));
    assign near_unlock = (dt_ext < (33'(cfg.button_high) + TOL))
                      && ((dt_ext + TOL) > 33'(cfg.button_high));

    // Build the result and the next state
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            last_time_next[i] = last_time_reg[i];
        end
        lock_next = lock_reg;

        rsp                = '0;
        rsp.width_accepted = in_win;
        rsp.measured_width = ch_valid ? ((dt[31:16] != '0) ? 16'hFFFF : dt[15:0]) : 16'd0;

        case (req.req_type)
            CH_MOTOR:
            begin
                last_time_next[0] = req.edge_time;
                if (in_win && !lock_reg)
                begin
                    rsp.motor_write   = 1'b1;
                    rsp.motor_command = dt_sat12;
                end
            end
            CH_SERVO:
            begin
                last_time_next[1] = req.edge_time;
                if (in_win && !lock_reg)
                begin
                    rsp.servo_write   = 1'b1;
                    rsp.servo_command = dt_sat12;
                end
            end
            CH_SWITCH:
            begin
                last_time_next[2] = req.edge_time;
                // Lock first with neutral commands, then let unlock win
                if (in_win && near_lock)
                begin
                    lock_next         = 1'b1;
                    rsp.motor_write   = 1'b1;
                    rsp.motor_command = cfg.motor_neutral;
                    rsp.servo_write   = 1'b1;
                    rsp.servo_command = cfg.servo_neutral;
                end
                if (in_win && near_unlock)
                begin
                    lock_next = 1'b0;
                end
            end
            default:
            begin
                lock_next = lock_reg;
            end
        endcase

        rsp.locked = lock_next;
        rsp.led_on = lock_next;
    end

    // Advance the channel state when the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                last_time_reg[i] <= '0;
            end
            lock_reg <= 1'b1;
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                last_time_reg[i] <= last_time_next[i];
            end
            lock_reg <= lock_next;
        end
    end

endmodule

### rtl/core/rc_pulse_capture_with_arming_core.sv
// RC pulse capture with arming lock, top level.
// An accepted request goes through the input register, then the result register.
// Throughput: one request per cycle while req_stall is low; a stalled full result register
// backs up into the input register, which then raises req_stall.
// Reset: last edge times clear to zero, block starts locked, registers take default values.
// Depends on rcpc_pkg, rcpc_cfg_regs and rcpc_measure.
module rc_pulse_capture_with_arming_core #(
    parameter int ARM_TOLERANCE = 50
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  rcpc_pkg::cfg_idx_t cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  rcpc_pkg::req_t     req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rcpc_pkg::rsp_t     rsp_data
);
    import rcpc_pkg::*;

    cfg_t cfg;
    req_t req_data_reg;
    logic req_valid_reg;
    rsp_t rsp_data_reg;
    logic rsp_valid_reg;
    rsp_t rsp_next;
    logic out_ready;
    logic advance;

    rcpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcpc_measure #(
        .ARM_TOLERANCE (ARM_TOLERANCE)
    ) u_measure (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req_data_reg),
        .advance (advance),
        .rsp     (rsp_next)
    );

    // Move a request forward whenever the result register frees up
    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign advance   = req_valid_reg && out_ready;
    assign req_stall = req_valid_reg && !out_ready;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_valid_reg <= req_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_data_reg <= req_data;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

### dv/rcpc_capture_checker.sv
// Checker for the RC pulse capture core: predicts each result and compares it.
// Tracks channel edge times, widths, the arming lock and the register file.
// Depends on rcpc_pkg.
module rcpc_capture_checker #(
    parameter int ARM_TOLERANCE = 50
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  rcpc_pkg::cfg_idx_t cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               req_valid,
    input  logic               req_stall,
    input  rcpc_pkg::req_t     req_data,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  rcpc_pkg::rsp_t     rsp_data,
    output int                 pending,
    output int                 mismatches
);
    import rcpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted state of the block
    cfg_t        regs;
    logic [31:0] last_edge [NUM_CH];
    logic [11:0] motor_width;
    logic [11:0] servo_width;
    logic [11:0] switch_width;
    logic        lock_flag;

    rsp_t        due_captures [$];
    int unsigned result_count;

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s got %0h want %0h",
                                      result_count, field, got, want));
    endtask

    // Window test: dt*5 > low*4 and dt*5 < high*6, no rounding
    function automatic bit in_band(logic [31:0] dt, logic [11:0] lo, logic [11:0] hi);
        longint unsigned d5, lo4, hi6;
        d5 = 64'(dt);
        lo4 = 64'(lo);
        hi6 = 64'(hi);
        d5 = d5 * 5;
        lo4 = lo4 * 4;
        hi6 = hi6 * 6;
        return (d5 > lo4) && (d5 < hi6);
    endfunction

    // Arming test on the full interval
    function automatic bit near_stop(logic [31:0] dt, logic [11:0] pos);
        longint a, b, diff;
        a = longint'(dt);
        b = longint'(pos);
        diff = a - b;
        if (diff < 0)
            diff = -diff;
        return diff < longint'(ARM_TOLERANCE);
    endfunction

    function automatic logic [11:0] clip12(logic [31:0] v);
        return (v > 32'hFFF) ? 12'hFFF : v[11:0];
    endfunction

    // Work out the result of one edge and advance the state
    function automatic rsp_t measure_edge(req_t r);
        rsp_t        o;
        logic [31:0] dt;
        logic [11:0] lo, hi;
        bit          known;
        o = '0;
        known = 1'b1;
        lo = '0;
        hi = '0;
        case (r.req_type)
            CH_MOTOR:  begin lo = regs.motor_low;  hi = regs.motor_high;  end
            CH_SERVO:  begin lo = regs.servo_low;  hi = regs.servo_high;  end
            CH_SWITCH: begin lo = regs.button_low; hi = regs.button_high; end
            default:   known = 1'b0;
        endcase
        if (known)
        begin
            dt = r.edge_time - last_edge[r.req_type];
            o.measured_width = (dt > 32'hFFFF) ? 16'hFFFF : dt[15:0];
            if (in_band(dt, lo, hi))
            begin
                o.width_accepted = 1'b1;
                case (r.req_type)
                    CH_MOTOR:
                    begin
                        motor_width = clip12(dt);
                        if (!lock_flag)
                        begin
                            o.motor_write = 1'b1;
                            o.motor_command = motor_width;
                        end
                    end
                    CH_SERVO:
                    begin
                        servo_width = clip12(dt);
                        if (!lock_flag)
                        begin
                            o.servo_write = 1'b1;
                            o.servo_command = servo_width;
                        end
                    end
                    default:
                    begin
                        // Lock first with neutral commands, then let unlock win
                        switch_width = clip12(dt);
                        if (near_stop(dt, regs.button_low))
                        begin
                            lock_flag = 1'b1;
                            o.motor_write = 1'b1;
                            o.motor_command = regs.motor_neutral;
                            o.servo_write = 1'b1;
                            o.servo_command = regs.servo_neutral;
                        end
                        if (near_stop(dt, regs.button_high))
                            lock_flag = 1'b0;
                    end
                endcase
            end
            last_edge[r.req_type] = r.edge_time;
        end
        o.locked = lock_flag;
        o.led_on = lock_flag;
        return o;
    endfunction

    function automatic void write_reg(cfg_idx_t idx, logic [11:0] val);
        case (idx)
            REG_MOTOR_LOW:     regs.motor_low = val;
            REG_MOTOR_HIGH:    regs.motor_high = val;
            REG_SERVO_LOW:     regs.servo_low = val;
            REG_SERVO_HIGH:    regs.servo_high = val;
            REG_BUTTON_LOW:    regs.button_low = val;
            REG_BUTTON_HIGH:   regs.button_high = val;
            REG_MOTOR_NEUTRAL: regs.motor_neutral = val;
            REG_SERVO_NEUTRAL: regs.servo_neutral = val;
            default: ;
        endcase
    endfunction

    // Watch the request and result ports and the register port
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            regs = CFG_RESET;
            for (int i = 0; i < NUM_CH; i++)
                last_edge[i] = '0;
            motor_width = CFG_RESET.motor_neutral;
            servo_width = CFG_RESET.servo_neutral;
            switch_width = CFG_RESET.button_low;
            lock_flag = 1'b1;
            due_captures.delete();
            mismatches = 0;
            result_count = 0;
        end
        else
        begin
            // Compare a delivered result with the oldest prediction
            if (rsp_valid && !rsp_stall)
            begin
                if (due_captures.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none pending",
                                              result_count));
                else
                begin
                    want = due_captures.pop_front();
                    check_field("width_accepted", 16'(rsp_data.width_accepted),
                                16'(want.width_accepted));
                    check_field("measured_width", rsp_data.measured_width,
                                want.measured_width);
                    check_field("motor_write", 16'(rsp_data.motor_write),
                                16'(want.motor_write));
                    check_field("motor_command", 16'(rsp_data.motor_command),
                                16'(want.motor_command));
                    check_field("servo_write", 16'(rsp_data.servo_write),
                                16'(want.servo_write));
                    check_field("servo_command", 16'(rsp_data.servo_command),
                                16'(want.servo_command));
                    check_field("locked", 16'(rsp_data.locked), 16'(want.locked));
                    check_field("led_on", 16'(rsp_data.led_on), 16'(want.led_on));
                end
                result_count++;
            end
            if (cfg_write)
                write_reg(cfg_index, cfg_data);
            if (req_valid && !req_stall)
                due_captures.push_back(measure_edge(req_data));
        end
        pending = due_captures.size();
    end

endmodule

### dv/tb_top.sv
// Top of the RC pulse capture testbench: clock, reset, stimulus and verdict.
// Drives edge requests and register writes into the core; checking is done
// by rcpc_capture_checker. Depends on rcpc_pkg and the core.
module tb_top;
    import rcpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARM_TOL = 50;
    localparam logic [1:0] CH_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    cfg_idx_t    cfg_index = REG_MOTOR_LOW;
    logic [11:0] cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp_data;
    int          pending;
    int          mismatches;

    // Stimulus-side view of what has been programmed and sent
    cfg_t        cur_cfg = CFG_RESET;
    logic [31:0] sent_time [NUM_CH] = '{default: '0};
    bit          steady = 1'b0;

    rc_pulse_capture_with_arming_core #(
        .ARM_TOLERANCE(ARM_TOL)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    rcpc_capture_checker #(
        .ARM_TOLERANCE(ARM_TOL)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data),
        .pending    (pending),
        .mismatches (mismatches)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Stall results at random unless in a steady stretch
    always @(negedge clk)
        rsp_stall <= !steady && ($urandom_range(99) < 34);

    // Hard stop in case the core hangs
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one edge request and hold it until accepted
    task automatic send_edge(logic [1:0] ch, logic [31:0] t);
        req_t r;
        r.req_type = ch;
        r.edge_time = t;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 34)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (req_stall);
        if (ch != CH_UNUSED)
            sent_time[ch] = t;
    endtask

    task automatic send_gap(logic [1:0] ch, int unsigned dt);
        send_edge(ch, sent_time[ch] + dt);
    endtask

    // Drop valid and wait until every pending result is out
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic load_config(cfg_t c);
        write_reg(REG_MOTOR_LOW, c.motor_low);
        write_reg(REG_MOTOR_HIGH, c.motor_high);
        write_reg(REG_SERVO_LOW, c.servo_low);
        write_reg(REG_SERVO_HIGH, c.servo_high);
        write_reg(REG_BUTTON_LOW, c.button_low);
        write_reg(REG_BUTTON_HIGH, c.button_high);
        write_reg(REG_MOTOR_NEUTRAL, c.motor_neutral);
        write_reg(REG_SERVO_NEUTRAL, c.servo_neutral);
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.motor_low = 12'($urandom_range(1600, 400));
        c.motor_high = c.motor_low + 12'($urandom_range(1500, 100));
        c.servo_low = 12'($urandom_range(1600, 400));
        c.servo_high = c.servo_low + 12'($urandom_range(1500, 100));
        c.button_low = 12'($urandom_range(1400, 800));
        // Keep the two positions close now and then so both can match
        c.button_high = c.button_low + 12'($urandom_range(700, 0));
        c.motor_neutral = 12'($urandom_range(4095));
        c.servo_neutral = 12'($urandom_range(4095));
        return c;
    endfunction

    // Pick an interval that lands in, on or near the channel window
    function automatic int unsigned pick_gap(logic [1:0] ch);
        int lo, hi, a, b, g;
        case (ch)
            CH_MOTOR:
            begin
                lo = int'(cur_cfg.motor_low);
                hi = int'(cur_cfg.motor_high);
            end
            CH_SERVO:
            begin
                lo = int'(cur_cfg.servo_low);
                hi = int'(cur_cfg.servo_high);
            end
            default:
            begin
                lo = int'(cur_cfg.button_low);
                hi = int'(cur_cfg.button_high);
            end
        endcase
        a = lo * 4 / 5;
        b = hi * 6 / 5;
        case ($urandom_range(9))
            5:       g = a + int'($urandom_range(2)) - 1;
            6:       g = b + int'($urandom_range(2)) - 1;
            7:       g = int'(cur_cfg.button_low) + int'($urandom_range(110)) - 55;
            8:       g = int'(cur_cfg.button_high) + int'($urandom_range(110)) - 55;
            9:       g = int'($urandom_range(70000));
            default: g = int'($urandom_range(b + 2, (a > 2) ? a - 2 : 0));
        endcase
        if (g < 0)
            g = 0;
        return unsigned'(g);
    endfunction

    // Mostly well-formed edge trains, some noise and backward stamps
    task automatic run_random(int n);
        logic [1:0] ch;
        int unsigned pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            ch = 2'($urandom_range(2));
            if (pick < 72)
                send_gap(ch, pick_gap(ch));
            else if (pick < 84)
                send_edge(2'($urandom_range(3)), $urandom);
            else if (pick < 92)
                send_edge(CH_UNUSED, $urandom);
            else
                send_edge(ch, sent_time[ch] - $urandom_range(5000, 1));
        end
    endtask

    initial
    begin
        cfg_t c;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default registers: window edges, arming, unused code, wrap
        send_gap(CH_MOTOR, 1500);
        send_gap(CH_SERVO, 1200);
        send_gap(CH_SWITCH, 1710);
        send_gap(CH_MOTOR, 1600);
        send_gap(CH_SERVO, 1000);
        send_gap(CH_MOTOR, 976);
        send_gap(CH_MOTOR, 977);
        send_gap(CH_MOTOR, 2414);
        send_gap(CH_MOTOR, 2415);
        send_gap(CH_SWITCH, 1204);
        send_gap(CH_SWITCH, 1253);
        send_gap(CH_SWITCH, 1254);
        send_gap(CH_SWITCH, 1661);
        send_edge(CH_UNUSED, $urandom);
        send_edge(CH_MOTOR, sent_time[CH_MOTOR] - 1);
        send_gap(CH_MOTOR, 70000);
        send_edge(CH_SERVO, 32'hFFFF_FFFF);
        send_edge(CH_SERVO, 32'd1200);
        send_edge(CH_UNUSED, 32'hFFFF_FFFF);
        send_edge(CH_SWITCH, 32'hFFFF_FFFF);
        send_edge(CH_SWITCH, 32'd0);
        settle();

        // Overlapping lock and unlock positions, wide motor and servo windows
        c = CFG_RESET;
        c.button_low = 12'd1500;
        c.button_high = 12'd1540;
        c.motor_high = 12'd4095;
        c.servo_high = 12'd3500;
        load_config(c);
        send_gap(CH_SWITCH, 1520);
        send_gap(CH_MOTOR, 4500);
        send_gap(CH_SERVO, 4000);
        send_gap(CH_SWITCH, 1480);
        send_gap(CH_MOTOR, 1300);
        send_gap(CH_SWITCH, 1560);
        settle();

        load_config(CFG_RESET);
        run_random(250);
        settle();

        load_config(random_cfg());
        run_random(250);
        settle();

        // Every register at zero: nothing can be accepted
        load_config('0);
        run_random(100);
        settle();

        // Every register at full scale
        load_config('1);
        run_random(250);
        settle();

        // Widest windows with the arming positions at the extremes
        c = '1;
        c.motor_low = '0;
        c.servo_low = '0;
        c.button_low = '0;
        c.motor_neutral = '0;
        c.servo_neutral = '0;
        load_config(c);
        run_random(250);
        settle();

        // Back-to-back stretch with no idling on either side
        load_config(random_cfg());
        steady = 1'b1;
        run_random(250);
        settle();
        steady = 1'b0;

        load_config(random_cfg());
        run_random(370);
        settle();

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
